// ===== sv/pdpa_pkg.sv =====
package pdpa_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int W_SEG  = 25;
    localparam int W_RAD  = 24;
    localparam int W_TRI  = 33;
    localparam int W_QUAD = 34;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by_coord;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
    } t_in;

    typedef struct packed {
        logic [W_SEG-1:0]  segment_length;
        logic [W_RAD-1:0]  first_radius;
        logic [W_RAD-1:0]  second_radius;
        logic [W_TRI-1:0]  triangle_area_twice;
        logic [W_QUAD-1:0] quad_area_twice;
    } t_out;

endpackage

// ===== sv/point_distance_and_polygon_area.sv =====
// Point distances and twice the areas of a triangle and a quadrilateral.
// Input: raise i_start with four points on i_item; the item transfers at
// the edge where i_start is high and o_busy is low. o_busy stays low, so
// one item can transfer every cycle.
// Output: each result appears on o_result for one cycle with o_done high.
// The receiver cannot stall; every result must be taken in that cycle.
// Pipeline: the front registers differences, products and sums, then the
// queue holds the item, then one pipelined square root stage per root bit,
// COORD_BITS + 1 + FRAC_BITS stages (25 by default), and an output register.
// Throughput: one item per cycle, set by the fully pipelined multipliers
// and the stage-per-bit square root units.
// Lengths are floor(sqrt) with FRAC_BITS fraction bits; areas are exact
// absolute cross products.
// Reset: synchronous, active low; clears all valid flags, drops items in
// flight. No clearing pass is needed.
module point_distance_and_polygon_area #(
    parameter int COORD_BITS = pdpa_pkg::COORD_BITS,
    parameter int FRAC_BITS  = pdpa_pkg::FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pdpa_pkg::t_in  i_item,
    output logic           o_busy,
    output logic           o_done,
    output pdpa_pkg::t_out o_result
);
    localparam int SQ_BITS = 2 * COORD_BITS + 2;
    localparam int QW = 3 * SQ_BITS + pdpa_pkg::W_TRI + pdpa_pkg::W_QUAD;

    logic accept, f_valid, q_valid;
    logic [SQ_BITS-1:0] f_seg, f_a, f_b, q_seg, q_a, q_b;
    logic [pdpa_pkg::W_TRI-1:0]  f_tri, q_tri;
    logic [pdpa_pkg::W_QUAD-1:0] f_quad, q_quad;

    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    pdpa_front #(.COORD_BITS(COORD_BITS), .SQ_BITS(SQ_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_item(i_item),
        .o_valid(f_valid), .o_d_seg(f_seg), .o_d_a(f_a), .o_d_b(f_b),
        .o_tri(f_tri), .o_quad(f_quad)
    );

    pdpa_queue #(.WIDTH(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_valid),
        .i_data({f_seg, f_a, f_b, f_tri, f_quad}),
        .o_valid(q_valid), .o_data({q_seg, q_a, q_b, q_tri, q_quad})
    );

    pdpa_back #(.SQ_BITS(SQ_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid),
        .i_d_seg(q_seg), .i_d_a(q_a), .i_d_b(q_b), .i_tri(q_tri), .i_quad(q_quad),
        .o_valid(o_done), .o_result(o_result)
    );

    a_quad_ge_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.quad_area_twice >= 34'(o_result.triangle_area_twice))
        else $error("quad area below triangle area");

    a_front_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 f_valid)
        else $error("front lost a transfer");

    a_tri_le_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> f_quad >= 34'(f_tri))
        else $error("front area sum wrong");
endmodule

// ===== sv/pdpa_front.sv =====
module pdpa_front #(
    parameter int COORD_BITS = pdpa_pkg::COORD_BITS,
    parameter int SQ_BITS    = 2 * COORD_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  pdpa_pkg::t_in         i_item,
    output logic                  o_valid,
    output logic [SQ_BITS-1:0]    o_d_seg,
    output logic [SQ_BITS-1:0]    o_d_a,
    output logic [SQ_BITS-1:0]    o_d_b,
    output logic [pdpa_pkg::W_TRI-1:0]  o_tri,
    output logic [pdpa_pkg::W_QUAD-1:0] o_quad
);
    localparam int DB = COORD_BITS + 1;
    localparam int PB = 2 * DB;

    logic             r_v1, r_v2;
    logic signed [DB-1:0] r_ux, r_uy, r_vx, r_vy, r_wx, r_wy;
    logic signed [DB-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [PB-1:0] r_p1, r_p2, r_p3, r_p4;
    logic [PB-1:0] r_sux, r_suy, r_sax, r_say, r_sbx, r_sby;
    logic signed [PB:0] c1, c2;
    logic [pdpa_pkg::W_TRI-1:0] t1, t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_ax <= DB'(i_item.ax);
        r_ay <= DB'(i_item.ay);
        r_bx <= DB'(i_item.bx);
        r_by <= DB'(i_item.by_coord);
        r_ux <= DB'(i_item.bx) - DB'(i_item.ax);
        r_uy <= DB'(i_item.by_coord) - DB'(i_item.ay);
        r_vx <= DB'(i_item.cx) - DB'(i_item.ax);
        r_vy <= DB'(i_item.cy) - DB'(i_item.ay);
        r_wx <= DB'(i_item.dx) - DB'(i_item.ax);
        r_wy <= DB'(i_item.dy) - DB'(i_item.ay);
        r_p1 <= r_ux * r_vy;
        r_p2 <= r_uy * r_vx;
        r_p3 <= r_wx * r_vy;
        r_p4 <= r_wy * r_vx;
        r_sux <= PB'(r_ux * r_ux);
        r_suy <= PB'(r_uy * r_uy);
        r_sax <= PB'(r_ax * r_ax);
        r_say <= PB'(r_ay * r_ay);
        r_sbx <= PB'(r_bx * r_bx);
        r_sby <= PB'(r_by * r_by);
    end

    always_comb begin
        c1 = (PB+1)'(r_p1) - (PB+1)'(r_p2);
        c2 = (PB+1)'(r_p3) - (PB+1)'(r_p4);
        t1 = pdpa_pkg::W_TRI'(c1 < 0 ? -c1 : c1);
        t2 = pdpa_pkg::W_TRI'(c2 < 0 ? -c2 : c2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v2;
        end
        o_d_seg <= SQ_BITS'(r_sux) + SQ_BITS'(r_suy);
        o_d_a   <= SQ_BITS'(r_sax) + SQ_BITS'(r_say);
        o_d_b   <= SQ_BITS'(r_sbx) + SQ_BITS'(r_sby);
        o_tri   <= t1;
        o_quad  <= pdpa_pkg::W_QUAD'(t1) + pdpa_pkg::W_QUAD'(t2);
    end
endmodule

// ===== sv/pdpa_queue.sv =====
module pdpa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pdpa_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             pop;

    assign pop     = r_cnt != '0;
    assign o_valid = pop;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

// ===== sv/pdpa_sqrt.sv =====
module pdpa_sqrt #(
    parameter int IN_BITS   = 34,
    parameter int FRAC_BITS = pdpa_pkg::FRAC_BITS,
    parameter int TAG_BITS  = 1,
    parameter int ROOT_BITS = (IN_BITS + 1) / 2 + FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IN_BITS-1:0]   i_val,
    input  logic [TAG_BITS-1:0]  i_tag,
    output logic [ROOT_BITS-1:0] o_root,
    output logic [TAG_BITS-1:0]  o_tag
);
    localparam int RB = ROOT_BITS;
    localparam int XB = 2 * RB;
    localparam int MB = RB + 2;

    logic [XB-1:0]   r_x    [RB+1];
    logic [RB-1:0]   r_root [RB+1];
    logic [MB-1:0]   r_rem  [RB+1];
    logic [TAG_BITS-1:0] r_tag [RB+1];

    always_comb begin
        r_x[0]    = XB'(i_val) << (2 * FRAC_BITS);
        r_root[0] = '0;
        r_rem[0]  = '0;
        r_tag[0]  = i_tag;
    end

    for (genvar s = 0; s < RB; s++) begin : g_stage
        logic [MB-1:0] rem_sh, trial;
        always_comb begin
            rem_sh = {r_rem[s][MB-3:0], r_x[s][XB-1 -: 2]};
            trial  = {r_root[s], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s+1] <= '0;
            end else begin
                r_tag[s+1] <= r_tag[s];
            end
            r_x[s+1]   <= r_x[s] << 2;
            if (rem_sh >= trial) begin
                r_rem[s+1]  <= rem_sh - trial;
                r_root[s+1] <= {r_root[s][RB-2:0], 1'b1};
            end else begin
                r_rem[s+1]  <= rem_sh;
                r_root[s+1] <= {r_root[s][RB-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[RB];
    assign o_tag  = r_tag[RB];
endmodule

// ===== sv/pdpa_back.sv =====
module pdpa_back #(
    parameter int SQ_BITS   = 34,
    parameter int FRAC_BITS = pdpa_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SQ_BITS-1:0]  i_d_seg,
    input  logic [SQ_BITS-1:0]  i_d_a,
    input  logic [SQ_BITS-1:0]  i_d_b,
    input  logic [pdpa_pkg::W_TRI-1:0]  i_tri,
    input  logic [pdpa_pkg::W_QUAD-1:0] i_quad,
    output logic                o_valid,
    output pdpa_pkg::t_out      o_result
);
    localparam int RB = (SQ_BITS + 1) / 2 + FRAC_BITS;
    localparam int TB = 1 + pdpa_pkg::W_TRI + pdpa_pkg::W_QUAD;

    logic [RB-1:0] root_s, root_a, root_b;
    logic [TB-1:0] tag_in, tag_out;
    logic          r_valid;

    assign tag_in = {i_valid & i_rst_n, i_tri, i_quad};

    pdpa_sqrt #(.IN_BITS(SQ_BITS), .FRAC_BITS(FRAC_BITS), .TAG_BITS(TB)) u_sqrt_seg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_val(i_d_seg), .i_tag(tag_in),
        .o_root(root_s), .o_tag(tag_out)
    );
    pdpa_sqrt #(.IN_BITS(SQ_BITS), .FRAC_BITS(FRAC_BITS), .TAG_BITS(1)) u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_val(i_d_a), .i_tag(1'b0),
        .o_root(root_a), .o_tag()
    );
    pdpa_sqrt #(.IN_BITS(SQ_BITS), .FRAC_BITS(FRAC_BITS), .TAG_BITS(1)) u_sqrt_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_val(i_d_b), .i_tag(1'b0),
        .o_root(root_b), .o_tag()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= tag_out[TB-1];
        end
        o_result.segment_length      <= pdpa_pkg::W_SEG'(root_s);
        o_result.first_radius        <= pdpa_pkg::W_RAD'(root_a);
        o_result.second_radius       <= pdpa_pkg::W_RAD'(root_b);
        o_result.triangle_area_twice <= tag_out[TB-2 -: pdpa_pkg::W_TRI];
        o_result.quad_area_twice     <= tag_out[pdpa_pkg::W_QUAD-1:0];
    end

    assign o_valid = r_valid;
endmodule
